[hdl/sag_pkg.sv]
// Package for the sound-activated gate.
// Holds the shared types, register codes and widths; no dependencies.
package sag_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 32;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [INDEX_W-1:0]         index_t;
    typedef logic [COUNT_W-1:0]         count_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    localparam cfg_idx_t REG_UPPER_THRESHOLD  = 2'd0;
    localparam cfg_idx_t REG_LOWER_THRESHOLD  = 2'd1;
    localparam cfg_idx_t REG_HANGOVER_SAMPLES = 2'd2;

    localparam sample_t RST_UPPER_THRESHOLD  = 16'sd1000;
    localparam sample_t RST_LOWER_THRESHOLD  = -16'sd1000;
    localparam index_t  RST_HANGOVER_SAMPLES = 32'd48000;

    typedef struct packed {
        sample_t upper_threshold;
        sample_t lower_threshold;
        index_t  hangover_samples;
    } cfg_t;

    typedef struct packed {
        logic    frame_quiet;
        logic    recording_now;
        count_t  active_frames;
        index_t  start_index;
        sample_t start_value;
        index_t  latest_index;
        sample_t latest_value;
    } result_t;

endpackage

[hdl/sag_if.sv]
// Stream interfaces of the sound-activated gate: sample input and frame result.
// Depends on sag_pkg.
interface sag_in_if
    import sag_pkg::*;
(
    input logic clk
);
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface sag_out_if
    import sag_pkg::*;
(
    input logic clk
);
    logic    valid;
    logic    ready;
    logic    frame_quiet;
    logic    recording_now;
    count_t  active_frames;
    index_t  start_index;
    sample_t start_value;
    index_t  latest_index;
    sample_t latest_value;

    modport source (
        output valid, output frame_quiet, output recording_now, output active_frames,
        output start_index, output start_value, output latest_index, output latest_value,
        input ready
    );
    modport sink (
        input valid, input frame_quiet, input recording_now, input active_frames,
        input start_index, input start_value, input latest_index, input latest_value,
        output ready
    );
endinterface

[hdl/sound_activated_gate.sv]
// Top level of the sound-activated gate with hangover.
// Depends on sag_pkg, sag_if, sag_cfg_regs, sag_tracker and sag_out_reg.

// The gate takes one signed 16-bit sample per item on the audio channel and
// gives one result item on the result channel for each sample flagged as a
// frame end, none for the others. It accepts one item every clock cycle: a
// sample is held in an input register, the compare and state update
// run on the sample in that register, and a frame result lands in a
// result register. Only a frame-end sample can stall, and
// only while the previous result still waits to be taken. A sample is loud when
// it is above upper_threshold or below lower_threshold (signed compares, applied
// as written even if the thresholds cross). Recording turns on with any loud
// sample; at a quiet frame end it turns off once the wrapping distance from the
// last loud sample index to the index after the frame exceeds hangover_samples.
// active_frames counts loud frames, saturates, and clears when recording was off
// at frame start and is off at frame end. Register indexes: 0 upper_threshold,
// 1 lower_threshold, 2 hangover_samples; index 3 is ignored. Write registers
// only while the gate is idle.
module sound_activated_gate
    import sag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sag_in_if.sink    audio,
    sag_out_if.source result,
    input  logic      cfg_we,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_wdata
);

    cfg_t    cfg;
    logic    out_room;
    logic    res_load;
    result_t res_data;

    // Hold the thresholds and hangover length.
    sag_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Register each sample, then advance the gate state and form the frame result.
    sag_tracker u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .audio    (audio),
        .cfg      (cfg),
        .out_room (out_room),
        .res_load (res_load),
        .res_data (res_data)
    );

    // Hold the frame result until the sink takes it.
    sag_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res_data (res_data),
        .out_room (out_room),
        .result   (result)
    );

endmodule

[hdl/sag_cfg_regs.sv]
// Configuration registers of the sound-activated gate.
// Depends on sag_pkg.
module sag_cfg_regs
    import sag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_wdata,
    output cfg_t      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_threshold  <= RST_UPPER_THRESHOLD;
            cfg_reg.lower_threshold  <= RST_LOWER_THRESHOLD;
            cfg_reg.hangover_samples <= RST_HANGOVER_SAMPLES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UPPER_THRESHOLD:  cfg_reg.upper_threshold  <= cfg_wdata[SAMPLE_W-1:0];
                REG_LOWER_THRESHOLD:  cfg_reg.lower_threshold  <= cfg_wdata[SAMPLE_W-1:0];
                REG_HANGOVER_SAMPLES: cfg_reg.hangover_samples <= cfg_wdata[INDEX_W-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/sag_tracker.sv]
// Input register and per-sample gate state update of the sound-activated gate.
// Depends on sag_pkg and sag_if.
module sag_tracker
    import sag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sag_in_if.sink   audio,
    input  cfg_t     cfg,
    input  logic     out_room,
    output logic     res_load,
    output result_t  res_data
);

    logic    s1_valid_reg;
    sample_t s1_sample_reg;
    logic    s1_last_reg;

    index_t  sample_index_reg, sample_index_next;
    index_t  loud_index_reg,   loud_index_next;
    sample_t loud_value_reg,   loud_value_next;
    index_t  first_index_reg,  first_index_next;
    sample_t first_value_reg,  first_value_next;
    logic    is_recording_reg, is_recording_next;
    logic    was_recording_reg, was_recording_next;
    count_t  frame_count_reg,  frame_count_next;
    logic    frame_all_quiet_reg, frame_all_quiet_next;
    logic    frame_open_reg,   frame_open_next;

    logic    advance;
    logic    loud;
    index_t  distance;

    // A frame-end item needs space in the result register; others never stall.
    assign advance     = s1_valid_reg && (!s1_last_reg || out_room);
    assign audio.ready = !s1_valid_reg || advance;
    assign res_load    = advance && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (audio.valid && audio.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (audio.valid && audio.ready)
        begin
            s1_sample_reg <= audio.sample;
            s1_last_reg   <= audio.frame_end;
        end
    end

    assign loud = (s1_sample_reg > cfg.upper_threshold) ||
                  (s1_sample_reg < cfg.lower_threshold);
    assign distance = sample_index_next - loud_index_next;

    always_comb
    begin
        sample_index_next    = sample_index_reg + 1'b1;
        loud_index_next      = loud_index_reg;
        loud_value_next      = loud_value_reg;
        first_index_next     = first_index_reg;
        first_value_next     = first_value_reg;
        is_recording_next    = is_recording_reg;
        frame_count_next     = frame_count_reg;
        was_recording_next   = frame_open_reg ? was_recording_reg : is_recording_reg;
        frame_all_quiet_next = frame_open_reg ? frame_all_quiet_reg : 1'b1;
        frame_open_next      = !s1_last_reg;

        if (loud)
        begin
            frame_all_quiet_next = 1'b0;
            loud_index_next      = sample_index_reg;
            loud_value_next      = s1_sample_reg;
            if (!is_recording_reg)
            begin
                first_index_next  = sample_index_reg;
                first_value_next  = s1_sample_reg;
                is_recording_next = 1'b1;
            end
        end

        if (s1_last_reg)
        begin
            if (!frame_all_quiet_next)
            begin
                is_recording_next = 1'b1;
                if (frame_count_reg != '1)
                begin
                    frame_count_next = frame_count_reg + 1'b1;
                end
            end
            else if (distance > cfg.hangover_samples)
            begin
                is_recording_next = 1'b0;
            end
            if (!was_recording_next && !is_recording_next)
            begin
                frame_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg    <= '0;
            loud_index_reg      <= '0;
            loud_value_reg      <= '0;
            first_index_reg     <= '0;
            first_value_reg     <= '0;
            is_recording_reg    <= 1'b0;
            was_recording_reg   <= 1'b0;
            frame_count_reg     <= '0;
            frame_all_quiet_reg <= 1'b1;
            frame_open_reg      <= 1'b0;
        end
        else if (advance)
        begin
            sample_index_reg    <= sample_index_next;
            loud_index_reg      <= loud_index_next;
            loud_value_reg      <= loud_value_next;
            first_index_reg     <= first_index_next;
            first_value_reg     <= first_value_next;
            is_recording_reg    <= is_recording_next;
            was_recording_reg   <= was_recording_next;
            frame_count_reg     <= frame_count_next;
            frame_all_quiet_reg <= frame_all_quiet_next;
            frame_open_reg      <= frame_open_next;
        end
    end

    always_comb
    begin
        res_data.frame_quiet   = frame_all_quiet_next;
        res_data.recording_now = is_recording_next;
        res_data.active_frames = frame_count_next;
        res_data.start_index   = first_index_next;
        res_data.start_value   = first_value_next;
        res_data.latest_index  = loud_index_next;
        res_data.latest_value  = loud_value_next;
    end

    a_loud_starts_recording: assert property (@(posedge clk) disable iff (!rst_n)
        advance && loud |=> is_recording_reg)
        else $error("loud sample did not set recording");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> sample_index_reg == $past(sample_index_reg) + 32'd1)
        else $error("sample index did not advance by one");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> audio.ready)
        else $error("empty input stage refused an item");

endmodule

[hdl/sag_out_reg.sv]
// Result register of the sound-activated gate, driving the result channel.
// Depends on sag_pkg and sag_if.
module sag_out_reg
    import sag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_load,
    input  result_t   res_data,
    output logic      out_room,
    sag_out_if.source result
);

    logic    valid_reg;
    result_t data_reg;

    assign out_room = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res_data;
        end
    end

    assign result.valid         = valid_reg;
    assign result.frame_quiet   = data_reg.frame_quiet;
    assign result.recording_now = data_reg.recording_now;
    assign result.active_frames = data_reg.active_frames;
    assign result.start_index   = data_reg.start_index;
    assign result.start_value   = data_reg.start_value;
    assign result.latest_index  = data_reg.latest_index;
    assign result.latest_value  = data_reg.latest_value;

    a_loud_frame_records: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.frame_quiet |-> data_reg.recording_now)
        else $error("loud frame reported without recording");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_room)
        else $error("result loaded over an untaken result");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for sound_activated_gate: drives samples and register writes, predicts
// every frame result and checks it field by field. Depends on sag_pkg and sag_if.
module tb;
    import sag_pkg::*;

    // Index 3 has no register behind it; writes to it must be ignored.
    localparam cfg_idx_t REG_UNUSED = 2'd3;

    // Cycles to wait before any register write once results are in, since a
    // mid-frame sample gives no result to wait on.
    localparam int SETTLE_CYCLES = 8;
    // Longest stretch with no handshake on either channel: a long sender gap plus
    // a long receiver stall plus the settle time stays far below this.
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 115;

    // Tracks the gate's state and holds the frame results still owed by the block.
    class gate_tracker;
        sample_t upper_thr;
        sample_t lower_thr;
        index_t  hangover;
        index_t  next_index;
        index_t  loud_index;
        sample_t loud_value;
        index_t  first_index;
        sample_t first_value;
        logic    recording;
        logic    recording_at_open;
        logic    frame_loud;
        logic    frame_open;
        count_t  frames_active;
        result_t frames_due[$];
        int      errors;

        function new();
            upper_thr         = RST_UPPER_THRESHOLD;
            lower_thr         = RST_LOWER_THRESHOLD;
            hangover          = RST_HANGOVER_SAMPLES;
            next_index        = '0;
            loud_index        = '0;
            loud_value        = '0;
            first_index       = '0;
            first_value       = '0;
            recording         = 1'b0;
            recording_at_open = 1'b0;
            frame_loud        = 1'b0;
            frame_open        = 1'b0;
            frames_active     = '0;
            errors            = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, cfg_data_t data);
            case (idx)
                REG_UPPER_THRESHOLD:  upper_thr = sample_t'(data[SAMPLE_W-1:0]);
                REG_LOWER_THRESHOLD:  lower_thr = sample_t'(data[SAMPLE_W-1:0]);
                REG_HANGOVER_SAMPLES: hangover  = index_t'(data);
                default: ;
            endcase
        endfunction

        function void take_sample(sample_t s, logic last);
            result_t r;
            index_t  since_loud;
            if (!frame_open) begin
                recording_at_open = recording;
                frame_loud        = 1'b0;
                frame_open        = 1'b1;
            end
            if (s > upper_thr || s < lower_thr) begin
                frame_loud = 1'b1;
                loud_index = next_index;
                loud_value = s;
                if (!recording) begin
                    first_index = next_index;
                    first_value = s;
                    recording   = 1'b1;
                end
            end
            next_index = next_index + 1'b1;
            if (last) begin
                since_loud = next_index - loud_index;
                if (frame_loud) begin
                    recording = 1'b1;
                    if (frames_active != '1)
                        frames_active = frames_active + 1'b1;
                end
                else if (since_loud > hangover) begin
                    recording = 1'b0;
                end
                if (!recording_at_open && !recording)
                    frames_active = '0;
                frame_open      = 1'b0;
                r.frame_quiet   = !frame_loud;
                r.recording_now = recording;
                r.active_frames = frames_active;
                r.start_index   = first_index;
                r.start_value   = first_value;
                r.latest_index  = loud_index;
                r.latest_value  = loud_value;
                frames_due.push_back(r);
            end
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void match_frame(result_t got);
            result_t want;
            if (frames_due.size() == 0) begin
                $error("frame result arrived with none pending");
                errors++;
                return;
            end
            want = frames_due.pop_front();
            check_field("frame_quiet", want.frame_quiet, got.frame_quiet);
            check_field("recording_now", want.recording_now, got.recording_now);
            check_field("active_frames", want.active_frames, got.active_frames);
            check_field("start_index", want.start_index, got.start_index);
            check_field("start_value", want.start_value, got.start_value);
            check_field("latest_index", want.latest_index, got.latest_index);
            check_field("latest_value", want.latest_value, got.latest_value);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_wdata;

    sag_in_if  audio_if  (.clk(clk));
    sag_out_if result_if (.clk(clk));

    sound_activated_gate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .audio     (audio_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gate_tracker tracker;
    result_t     seen_frame;
    bit          steady;        // phase with no idling on either side
    int          loud_pct;      // share of samples drawn from the full range
    int          end_pct;       // share of samples that close a frame
    int          stall_left = 0;
    int          idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Draw a sample: some from the whole range (loud under most settings), a few
    // right on or just past a threshold, the rest inside the quiet band.
    function automatic sample_t next_sample();
        int      r;
        int      span;
        sample_t s;
        r = $urandom_range(0, 99);
        if (r < loud_pct) begin
            s = sample_t'($urandom);
        end
        else if (r < loud_pct + 5) begin
            case ($urandom_range(0, 3))
                0:       s = tracker.upper_thr;
                1:       s = sample_t'(int'(tracker.upper_thr) + 1);
                2:       s = tracker.lower_thr;
                default: s = sample_t'(int'(tracker.lower_thr) - 1);
            endcase
        end
        else if (tracker.lower_thr <= tracker.upper_thr) begin
            span = int'(tracker.upper_thr) - int'(tracker.lower_thr);
            s = sample_t'(int'(tracker.lower_thr) + int'($urandom_range(span, 0)));
        end
        else begin
            // Crossed thresholds leave no quiet band at all.
            s = sample_t'($urandom);
        end
        return s;
    endfunction

    // Offer one sample, hold it until taken, then record what it should cause.
    // Drop valid for a random gap afterwards unless the phase runs steady.
    task automatic push_sample(input sample_t s, input logic last);
        audio_if.valid     <= 1'b1;
        audio_if.sample    <= s;
        audio_if.frame_end <= last;
        do
            @(posedge clk);
        while (!audio_if.ready);
        tracker.take_sample(s, last);
        if (!steady && $urandom_range(0, 3) == 0) begin
            audio_if.valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // Stop sending, wait for every owed frame result, then let the pipeline empty.
    task automatic wait_results();
        audio_if.valid <= 1'b0;
        while (tracker.frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keep write enable high across back-to-back writes; the caller lowers it.
    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic program_gate(input int up, input int lo, input index_t hang,
                                input bit junk);
        write_reg(REG_UPPER_THRESHOLD, cfg_data_t'(up));
        write_reg(REG_LOWER_THRESHOLD, cfg_data_t'(lo));
        write_reg(REG_HANGOVER_SAMPLES, cfg_data_t'(hang));
        if (junk)
            write_reg(REG_UNUSED, cfg_data_t'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Directed samples under the reset register values (1000 / -1000 / 48000).
    task automatic run_directed();
        // Single-sample quiet frame before anything loud: start and latest stay 0.
        push_sample(16'sd0, 1'b1);
        // Samples right on the thresholds are not loud.
        push_sample(16'sd1000, 1'b0);
        push_sample(-16'sd1000, 1'b0);
        push_sample(16'sd0, 1'b1);
        // One sample just above: a single-sample loud frame starts recording.
        push_sample(16'sd1001, 1'b1);
        // Full-scale extremes and one just below the lower threshold.
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(-16'sd1001, 1'b1);
        // Quiet frame inside the hangover: recording holds.
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd1, 1'b1);
        // Alternating bit patterns, then all ones.
        push_sample(16'sh5555, 1'b0);
        push_sample(16'shAAAA, 1'b0);
        push_sample(16'shFFFF, 1'b1);
        push_sample(-16'sd999, 1'b1);
    endtask

    // Drive the result ready: random stalls, none started during steady phases.
    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            result_if.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 3) == 0) begin
            result_if.ready <= 1'b0;
            stall_left      <= gap_len() - 1;
        end
        else begin
            result_if.ready <= 1'b1;
        end
    end

    // Check each result item as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready) begin
            seen_frame.frame_quiet   = result_if.frame_quiet;
            seen_frame.recording_now = result_if.recording_now;
            seen_frame.active_frames = result_if.active_frames;
            seen_frame.start_index   = result_if.start_index;
            seen_frame.start_value   = result_if.start_value;
            seen_frame.latest_index  = result_if.latest_index;
            seen_frame.latest_value  = result_if.latest_value;
            tracker.match_frame(seen_frame);
        end
    end

    // Watchdog: end the run if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((audio_if.valid && audio_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT) begin
            $error("no item moved for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int     up;
        int     lo;
        index_t hang;
        tracker            = new();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_UPPER_THRESHOLD;
        cfg_wdata          = '0;
        audio_if.valid     = 1'b0;
        audio_if.sample    = '0;
        audio_if.frame_end = 1'b0;
        result_if.ready    = 1'b0;
        steady             = 1'b0;
        loud_pct           = 10;
        end_pct            = 25;

        // Hold reset at the start, then release it once.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int ph = 0; ph < PHASES; ph++) begin
            // Registers change only with the gate idle.
            wait_results();
            case (ph)
                0: begin
                    // Hangover of zero: the first quiet frame ends recording.
                    up = 1000; lo = -1000; hang = '0;
                end
                1: begin
                    // Widest quiet band: nothing is ever loud, the count clears.
                    up = 32767; lo = -32768; hang = index_t'($urandom_range(0, 20));
                end
                2: begin
                    // Crossed thresholds with the longest hangover.
                    up = -32768; lo = 32767; hang = '1;
                end
                3: begin
                    up = 0; lo = 0; hang = index_t'(1);
                end
                default: begin
                    up   = $urandom_range(0, 3000);
                    lo   = -int'($urandom_range(0, 3000));
                    hang = index_t'($urandom_range(0, 60));
                    if ($urandom_range(0, 3) == 0) begin
                        up = int'(sample_t'($urandom));
                        lo = int'(sample_t'($urandom));
                    end
                end
            endcase
            program_gate(up, lo, hang, (ph == 0) || (ph == 5));

            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       loud_pct = 2;
                1:       loud_pct = 10;
                default: loud_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       end_pct = 5;
                1:       end_pct = 25;
                default: end_pct = 60;
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Pause the sender mid-phase now and then until all results are in.
                if (n == PHASE_ITEMS / 2 && ph % 3 == 1)
                    wait_results();
                push_sample(next_sample(), $urandom_range(0, 99) < end_pct);
            end
        end

        wait_results();
        if (tracker.frames_due.size() != 0)
            $error("%0d frame results never arrived", tracker.frames_due.size());
        if (tracker.errors == 0 && tracker.frames_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
